>>> rtl/subscription_key_table_core_defines.svh
// Assertion macros shared by the subscription key table RTL.
`ifndef SUBSCRIPTION_KEY_TABLE_CORE_DEFINES_SVH
`define SUBSCRIPTION_KEY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/skt_pkg.sv
package skt_pkg;

	localparam int KEY_PORT_W = 64;

	typedef enum logic [1:0] {
		REQ_SUB,
		REQ_UNSUB,
		REQ_DISC
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESP
	} skt_state_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
	} tok_t;

endpackage

>>> rtl/subscription_key_table_core.sv
// Subscription key table: keeps up to MAX_KEYS keys in order of subscription in a row of
// slot cells. Subscribe and unsubscribe send a search token down the row, one cell per
// cycle, and the result is offered after the token leaves the last cell. Disconnect, the
// unused request kind and a subscribe for a key missing from the store skip the walk and
// go straight to the response state. The walk length is set by the chain depth.
// On an unsubscribe hit, the hit cell and those behind it pull their right neighbour's
// key as the token passes, closing the gap. Appends are written after the walk into the
// slot at the current count. One request is in progress at a time; a new one is taken the
// cycle after the previous result enters the output register.
`include "subscription_key_table_core_defines.svh"

module subscription_key_table_core
	import skt_pkg::*;
#(
	parameter int MAX_KEYS = 16,
	parameter int KEY_BITS = 64,
	localparam int CNT_W   = $clog2(MAX_KEYS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic [KEY_PORT_W-1:0] key,
	input  logic                  key_known,
	// response channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            resp_kind,
	output logic                  status,
	output logic [CNT_W-1:0]      entry_count
);

	skt_state_t          state_q, state_d;
	logic [1:0]          kind_q;
	logic [KEY_BITS-1:0] probe_q;
	logic                exists_q;
	logic                found_q;
	logic [CNT_W-1:0]    count_q;
	tok_t                inj_q;

	logic                out_valid_q;
	logic [1:0]          resp_kind_q;
	logic                status_q;
	logic [CNT_W-1:0]    entry_count_q;

	logic                accept;
	logic                load;
	logic                walk_needed;
	logic                do_append;
	logic                status_d;
	logic [CNT_W-1:0]    count_d;

	tok_t                tok_chain [MAX_KEYS+1];
	logic [KEY_BITS-1:0] key_vec   [MAX_KEYS];
	logic [MAX_KEYS-1:0] tok_vld;
	logic                is_unsub;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign load     = (state_q == ST_RESP) && (!out_valid_q || !out_stall);
	assign is_unsub = (kind_q == REQ_UNSUB);

	// only searches need the walk; a subscribe for a missing key changes nothing
	assign walk_needed = ((req_type == REQ_SUB) && key_known) || (req_type == REQ_UNSUB);

	assign tok_chain[0] = inj_q;

	// result and new count once the walk is over
	always_comb begin
		do_append = 1'b0;
		status_d  = 1'b0;
		count_d   = count_q;
		case (kind_q)
			REQ_SUB: begin
				status_d  = exists_q;
				do_append = exists_q && !found_q && (count_q < CNT_W'(MAX_KEYS));
				if (do_append) begin
					count_d = count_q + CNT_W'(1);
				end
			end
			REQ_UNSUB: begin
				status_d = !found_q;
				if (found_q) begin
					count_d = count_q - CNT_W'(1);
				end
			end
			REQ_DISC: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// slot chain
	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		logic [KEY_BITS-1:0] right_key;

		if (i == MAX_KEYS - 1) begin : g_last
			assign right_key = key_vec[i];
		end else begin : g_mid
			assign right_key = key_vec[i+1];
		end

		assign tok_vld[i] = tok_chain[i+1].valid;

		skt_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.live      (CNT_W'(i) < count_q),
			.unsub     (is_unsub),
			.probe     (probe_q),
			.wr_en     (load && do_append && (count_q == CNT_W'(i))),
			.tok_in    (tok_chain[i]),
			.tok_out   (tok_chain[i+1]),
			.right_key (right_key),
			.key_out   (key_vec[i])
		);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = walk_needed ? ST_WALK : ST_RESP;
				end
			end
			ST_WALK: begin
				if (tok_chain[MAX_KEYS].valid) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			inj_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			inj_q.valid <= accept && walk_needed;
			inj_q.found <= 1'b0;
			if (accept) begin
				found_q <= 1'b0;
			end else if ((state_q == ST_WALK) && tok_chain[MAX_KEYS].valid) begin
				found_q <= tok_chain[MAX_KEYS].found;
			end
			if (load) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request hold and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= req_type;
			probe_q  <= key[KEY_BITS-1:0];
			exists_q <= key_known;
		end
		if (load) begin
			resp_kind_q   <= kind_q;
			status_q      <= status_d;
			entry_count_q <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign resp_kind   = resp_kind_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	`SKT_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(MAX_KEYS), "slot count above capacity")
	`SKT_ASSERT_IMP(a_single_token, 1'b1, $onehot0(tok_vld), "more than one token in the chain")
	`SKT_ASSERT_IMP(a_token_in_walk, tok_vld != '0, state_q == ST_WALK, "token outside a walk")
	`SKT_ASSERT_NXT(a_unsub_dec, load && is_unsub && found_q, count_q == $past(count_q) - CNT_W'(1), "unsubscribe hit did not drop the count")

endmodule

>>> rtl/skt_cell.sv
module skt_cell
	import skt_pkg::*;
#(
	parameter int KEY_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                live,      // slot below current count
	input  logic                unsub,     // request being walked is an unsubscribe
	input  logic [KEY_BITS-1:0] probe,
	input  logic                wr_en,     // append probe into this slot
	input  tok_t                tok_in,
	output tok_t                tok_out,
	input  logic [KEY_BITS-1:0] right_key,
	output logic [KEY_BITS-1:0] key_out
);

	logic [KEY_BITS-1:0] key_q;
	tok_t                tok_q;
	tok_t                tok_d;
	logic                match;

	always_comb begin
		match       = tok_in.valid && live && (key_q == probe);
		tok_d.valid = tok_in.valid;
		tok_d.found = tok_in.valid && (tok_in.found || match);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// on an unsubscribe, once the token has passed a hit, each slot takes its right neighbour's key
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q <= probe;
		end else if (tok_q.valid && tok_q.found && unsub) begin
			key_q <= right_key;
		end
	end

	assign tok_out = tok_q;
	assign key_out = key_q;

endmodule
